### rtl/websocket_frame_deframer_core_macros.svh
// Assertion helpers for the checker of this block.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/wsfd_pkg.sv
package wsfd_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [3:0] opcode_t;

  localparam kind_t KIND_DATA  = 3'd0;
  localparam kind_t KIND_PONG  = 3'd1;
  localparam kind_t KIND_EMPTY = 3'd2;
  localparam kind_t KIND_CLOSE = 3'd3;
  localparam kind_t KIND_ERROR = 3'd4;

  localparam opcode_t OP_CLOSE = 4'h8;
  localparam opcode_t OP_PING  = 4'h9;
  localparam opcode_t OP_PONG  = 4'hA;

  localparam logic [6:0] LEN7_MAX   = 7'd125;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

### rtl/websocket_frame_deframer_core.sv
// WebSocket (client-to-server) frame deframer.
// Input channel: in_stream_byte, one stream byte per word, in_valid/in_ready.
// Result channel: out_kind, out_payload_byte, out_frame_opcode, out_fin_bit,
//   out_frame_last, out_message_last with out_valid/out_ready.
// Each accepted byte gives zero or one result word: unmasked data bytes,
// unmasked ping echo bytes, an empty-frame end, a close event or a
// protocol error. Header bytes give only errors, extended length bytes give
// nothing, and the last mask key byte gives only an empty-frame end or close.
// One byte is accepted per cycle while in_ready is high; the frame state update
// and the 64-bit length decrement/compare are combinational; results are registered.
// Stall: in_ready = !out_valid || out_ready, so a stalled receiver holds the
// pending result and the input waits; no word is lost or repeated.
// Reset (rst_n, synchronous, active low): parser returns to the first header
// byte and the output register is emptied. After a close event or a protocol
// error, input bytes are still accepted but ignored until the next reset.
module websocket_frame_deframer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_stream_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output wsfd_pkg::kind_t    out_kind,
  output logic [7:0]         out_payload_byte,
  output wsfd_pkg::opcode_t  out_frame_opcode,
  output logic               out_fin_bit,
  output logic               out_frame_last,
  output logic               out_message_last
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_DATA,
    PH_STOP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  opcode_t     opcode_r, opcode_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [63:0] rem_len_r, rem_len_nxt;
  logic [7:0]  mask_key_r [4];
  logic [7:0]  mask_key_nxt [4];
  logic [1:0]  mask_idx_r, mask_idx_nxt;

  logic        out_valid_r, out_valid_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  opcode_t     oop_r, oop_nxt;
  logic        ofin_r, ofin_nxt;
  logic        olast_r, olast_nxt;

  logic        in_fire;
  logic        res_valid;
  logic        data_last;
  logic [7:0]  plain;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign plain     = in_stream_byte ^ mask_key_r[mask_idx_r];
  assign data_last = (rem_len_r == 64'd1);

  always_comb begin
    phase_nxt    = phase_r;
    fin_nxt      = fin_r;
    opcode_nxt   = opcode_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    rem_len_nxt  = rem_len_r;
    mask_key_nxt = mask_key_r;
    mask_idx_nxt = mask_idx_r;
    res_valid    = 1'b0;
    kind_nxt     = KIND_DATA;
    pbyte_nxt    = 8'd0;
    olast_nxt    = 1'b0;

    if (in_fire) begin
      unique case (phase_r)
        PH_HDR0: begin
          fin_nxt    = in_stream_byte[7];
          opcode_nxt = in_stream_byte[3:0];
          if (in_stream_byte[6:4] != 3'd0) begin
            phase_nxt = PH_STOP;
            res_valid = 1'b1;
            kind_nxt  = KIND_ERROR;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          if (!in_stream_byte[7]) begin
            phase_nxt = PH_STOP;
            res_valid = 1'b1;
            kind_nxt  = KIND_ERROR;
          end else if (in_stream_byte[6:0] <= LEN7_MAX) begin
            rem_len_nxt = {57'd0, in_stream_byte[6:0]};
            hdr_cnt_nxt = 4'd0;
            phase_nxt   = PH_KEY;
          end else begin
            rem_len_nxt = 64'd0;
            hdr_cnt_nxt = (in_stream_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            phase_nxt   = PH_EXTLEN;
          end
        end
        PH_EXTLEN: begin
          // shift in big-endian length bytes
          rem_len_nxt = {rem_len_r[55:0], in_stream_byte};
          hdr_cnt_nxt = hdr_cnt_r - 4'd1;
          if (hdr_cnt_r == 4'd1) begin
            phase_nxt = PH_KEY;
          end
        end
        PH_KEY: begin
          mask_key_nxt[hdr_cnt_r[1:0]] = in_stream_byte;
          hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          if (hdr_cnt_nxt == KEY_BYTES) begin
            hdr_cnt_nxt  = 4'd0;
            mask_idx_nxt = 2'd0;
            if (rem_len_r == 64'd0) begin
              // empty frame ends right after the key
              phase_nxt = PH_HDR0;
              if (opcode_r == OP_CLOSE) begin
                phase_nxt = PH_STOP;
                res_valid = 1'b1;
                kind_nxt  = KIND_CLOSE;
                olast_nxt = 1'b1;
              end else if (opcode_r != OP_PONG) begin
                res_valid = 1'b1;
                kind_nxt  = KIND_EMPTY;
                olast_nxt = 1'b1;
              end
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          mask_idx_nxt = mask_idx_r + 2'd1;
          rem_len_nxt  = rem_len_r - 64'd1;
          if (data_last) begin
            phase_nxt = PH_HDR0;
          end
          if (opcode_r == OP_CLOSE) begin
            if (data_last) begin
              phase_nxt = PH_STOP;
              res_valid = 1'b1;
              kind_nxt  = KIND_CLOSE;
              olast_nxt = 1'b1;
            end
          end else if (opcode_r != OP_PONG) begin
            res_valid = 1'b1;
            kind_nxt  = (opcode_r == OP_PING) ? KIND_PONG : KIND_DATA;
            pbyte_nxt = plain;
            olast_nxt = data_last;
          end
        end
        default: begin
          // stopped: drop every byte
        end
      endcase
    end

    oop_nxt  = opcode_nxt;
    ofin_nxt = fin_nxt;
    if (in_ready) begin
      out_valid_nxt = in_fire && res_valid;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      fin_r       <= 1'b0;
      opcode_r    <= 4'd0;
      hdr_cnt_r   <= 4'd0;
      rem_len_r   <= 64'd0;
      mask_idx_r  <= 2'd0;
      mask_key_r  <= '{default: 8'd0};
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      fin_r       <= fin_nxt;
      opcode_r    <= opcode_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      rem_len_r   <= rem_len_nxt;
      mask_idx_r  <= mask_idx_nxt;
      mask_key_r  <= mask_key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload: load only with a new result word
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      kind_r  <= kind_nxt;
      pbyte_r <= pbyte_nxt;
      oop_r   <= oop_nxt;
      ofin_r  <= ofin_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_payload_byte = pbyte_r;
  assign out_frame_opcode = oop_r;
  assign out_fin_bit      = ofin_r;
  assign out_frame_last   = olast_r;
  assign out_message_last = olast_r && ofin_r;

endmodule

### rtl/wsfd_checker.sv
`include "websocket_frame_deframer_core_macros.svh"

module wsfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input wsfd_pkg::kind_t    out_kind,
  input logic [7:0]         out_payload_byte,
  input logic               out_fin_bit,
  input logic               out_frame_last,
  input logic               out_message_last
);
  import wsfd_pkg::*;

  `WSFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_kind) && $stable(out_payload_byte),
                    "result word changed while stalled")
  `WSFD_ASSERT_NOW(a_msg_last, out_valid,
                   out_message_last == (out_frame_last && out_fin_bit),
                   "message_last does not match frame_last and fin")
  `WSFD_ASSERT_NOW(a_event_zero,
                   out_valid && (out_kind == KIND_EMPTY || out_kind == KIND_CLOSE ||
                                 out_kind == KIND_ERROR),
                   out_payload_byte == 8'd0, "event word carries payload")
  `WSFD_ASSERT_NOW(a_err_not_last, out_valid && out_kind == KIND_ERROR, !out_frame_last,
                   "protocol error marked as frame end")
  `WSFD_ASSERT_NEXT(a_quiet_after_stop,
                    out_valid && out_ready && (out_kind == KIND_CLOSE || out_kind == KIND_ERROR),
                    !out_valid, "result after close or error")

endmodule

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_payload_byte (out_payload_byte),
  .out_fin_bit      (out_fin_bit),
  .out_frame_last   (out_frame_last),
  .out_message_last (out_message_last)
);

### dv/tb_top.sv
module tb_top;
  import wsfd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEMS_TARGET = 550;
  localparam int TAIL_CYCLES  = 10;
  localparam int PHASE_A_END  = 185;
  localparam int PHASE_B_END  = 370;
  localparam int DRAIN_AT     = 300;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 400;

  localparam opcode_t OP_CONT   = 4'h0;
  localparam opcode_t OP_TEXT   = 4'h1;
  localparam opcode_t OP_BINARY = 4'h2;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  typedef enum logic [2:0] {
    S_HDR0, S_HDR1, S_EXTLEN, S_KEY, S_PAYLOAD, S_HALT
  } parse_state_e;

  typedef enum int {LEN_FORM7, LEN_FORM16, LEN_FORM64} len_form_e;
  typedef enum int {END_CLOSE_EMPTY, END_CLOSE_DATA, END_BAD_RSV, END_NO_MASK} stream_end_e;

  typedef struct {
    logic [7:0] data;
    bit         drain_first;
  } stream_word_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    opcode_t    op;
    logic       fin;
    logic       frame_last;
    logic       msg_last;
  } deframed_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_stream_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  kind_t      out_kind;
  logic [7:0] out_payload_byte;
  opcode_t    out_frame_opcode;
  logic       out_fin_bit;
  logic       out_frame_last;
  logic       out_message_last;

  websocket_frame_deframer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_opcode (out_frame_opcode),
    .out_fin_bit      (out_fin_bit),
    .out_frame_last   (out_frame_last),
    .out_message_last (out_message_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stream_word_t   stream_q[$];
  deframed_word_t expected_words[$];
  stream_word_t   next_word;
  int             stream_len;
  int             bytes_sent;
  int             mismatches;
  int             cycles;
  int             stall_left;
  bit             stall_done;
  bit             drain_next;

  // Parser mirror
  parse_state_e ps = S_HDR0;
  bit           stream_closed;
  logic         cur_fin;
  opcode_t      cur_op;
  logic [3:0]   hdr_cnt;
  logic [63:0]  remain;
  logic [7:0]   mask_key [4];
  logic [1:0]   key_idx;

  function automatic void add_result(input kind_t kind, input logic [7:0] data,
                                     input logic last);
    deframed_word_t w;
    w.kind       = kind;
    w.data       = data;
    w.op         = cur_op;
    w.fin        = cur_fin;
    w.frame_last = last;
    w.msg_last   = last & cur_fin;
    expected_words.push_back(w);
  endfunction

  function automatic void end_empty_frame();
    ps = S_HDR0;
    if (cur_op == OP_CLOSE) begin
      stream_closed = 1'b1;
      add_result(KIND_CLOSE, 8'h00, 1'b1);
    end else if (cur_op != OP_PONG) begin
      add_result(KIND_EMPTY, 8'h00, 1'b1);
    end
  endfunction

  function automatic void parse_stream_byte(input logic [7:0] b);
    logic [7:0] plain;
    logic       last;
    if (stream_closed) return;
    case (ps)
      S_HDR0: begin
        cur_fin = b[7];
        cur_op  = b[3:0];
        if (b[6:4] != 3'b000) begin
          ps = S_HALT;
          add_result(KIND_ERROR, 8'h00, 1'b0);
        end else begin
          ps = S_HDR1;
        end
      end
      S_HDR1: begin
        if (!b[7]) begin
          ps = S_HALT;
          add_result(KIND_ERROR, 8'h00, 1'b0);
        end else begin
          remain  = '0;
          hdr_cnt = '0;
          if (b[6:0] <= LEN7_MAX) begin
            remain = {57'd0, b[6:0]};
            ps     = S_KEY;
          end else begin
            hdr_cnt = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            ps      = S_EXTLEN;
          end
        end
      end
      S_EXTLEN: begin
        remain  = {remain[55:0], b};
        hdr_cnt = hdr_cnt - 4'd1;
        if (hdr_cnt == 4'd0) ps = S_KEY;
      end
      S_KEY: begin
        mask_key[hdr_cnt[1:0]] = b;
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt == KEY_BYTES) begin
          hdr_cnt = '0;
          key_idx = '0;
          if (remain == 64'd0) end_empty_frame();
          else ps = S_PAYLOAD;
        end
      end
      S_PAYLOAD: begin
        plain   = b ^ mask_key[key_idx];
        key_idx = key_idx + 2'd1;
        remain  = remain - 64'd1;
        last    = (remain == 64'd0);
        if (last) ps = S_HDR0;
        if (cur_op == OP_CLOSE) begin
          if (last) begin
            stream_closed = 1'b1;
            add_result(KIND_CLOSE, 8'h00, 1'b1);
          end
        end else if (cur_op == OP_PING) begin
          add_result(KIND_PONG, plain, last);
        end else if (cur_op != OP_PONG) begin
          add_result(KIND_DATA, plain, last);
        end
      end
      default: ;
    endcase
  endfunction

  // Stream building
  function automatic void put_byte(input logic [7:0] v);
    stream_word_t w;
    w.data        = v;
    w.drain_first = drain_next;
    drain_next    = 1'b0;
    stream_q.push_back(w);
  endfunction

  function automatic void put_header(input logic fin, input logic [2:0] rsv, input opcode_t op,
                                     input logic [63:0] len, input len_form_e form,
                                     input logic [31:0] key);
    put_byte({fin, rsv, op});
    case (form)
      LEN_FORM16: begin
        put_byte({1'b1, LEN7_EXT16});
        put_byte(len[15:8]);
        put_byte(len[7:0]);
      end
      LEN_FORM64: begin
        put_byte({1'b1, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) put_byte(len[8*i +: 8]);
      end
      default: put_byte({1'b1, len[6:0]});
    endcase
    for (int i = 3; i >= 0; i--) put_byte(key[8*i +: 8]);
  endfunction

  function automatic void put_frame(input logic fin, input opcode_t op,
                                    input logic [63:0] len, input len_form_e form);
    put_header(fin, 3'b000, op, len, form, $urandom);
    for (longint i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_random_frame();
    opcode_t     op;
    logic [63:0] len;
    len_form_e   form;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = opcode_t'($urandom_range(0, 2));
    else if (pick < 62) op = OP_PING;
    else if (pick < 75) op = OP_PONG;
    else begin
      // reserved codes only: 3..7 and B..F
      op = opcode_t'($urandom_range(3, 12));
      if (op >= OP_CLOSE) op = op + 4'd3;
    end
    pick = $urandom_range(0, 99);
    form = (pick < 80) ? LEN_FORM7 : (pick < 90) ? LEN_FORM16 : LEN_FORM64;
    pick = $urandom_range(0, 99);
    if (form == LEN_FORM7) begin
      if (pick < 15) len = 64'd0;
      else if (pick < 95) len = 64'($urandom_range(1, 6));
      else len = 64'($urandom_range(120, 125));
    end else begin
      len = (pick < 70) ? 64'($urandom_range(0, 8)) : 64'($urandom_range(120, 140));
    end
    put_frame(1'($urandom_range(0, 1)), op, len, form);
  endfunction

  function automatic void put_stream_end();
    stream_end_e how;
    how = stream_end_e'($urandom_range(0, 3));
    case (how)
      END_CLOSE_EMPTY: put_header(1'b1, 3'b000, OP_CLOSE, 64'd0, LEN_FORM7, $urandom);
      END_CLOSE_DATA:  put_frame(1'($urandom_range(0, 1)), OP_CLOSE,
                                 64'($urandom_range(1, 10)), LEN_FORM7);
      END_BAD_RSV:     put_byte({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                                 4'($urandom_range(0, 15))});
      default: begin
        put_byte({1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(0, 15))});
        put_byte({1'b0, 7'($urandom_range(0, 127))});
      end
    endcase
    // ignored after the stop
    for (int i = 0; i < 16; i++) put_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_stream();
    bit drain_placed;
    // extreme payload bytes with all-zero and all-one keys
    put_header(1'b1, 3'b000, OP_TEXT, 64'd2, LEN_FORM7, 32'h0000_0000);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_header(1'b0, 3'b000, OP_BINARY, 64'd0, LEN_FORM7, 32'hFFFF_FFFF);
    put_header(1'b1, 3'b000, OP_PING, 64'd1, LEN_FORM16, 32'hFFFF_FFFF);
    put_byte(8'hA5);
    put_header(1'b1, 3'b000, OP_PONG, 64'd0, LEN_FORM7, $urandom);
    // long 64-bit length whose low byte has its top bit set
    put_frame(1'b1, OP_CONT, 64'($urandom_range(128, 140)), LEN_FORM64);
    while (stream_q.size() < ITEMS_TARGET) begin
      if (stream_q.size() >= DRAIN_AT && !drain_placed) begin
        // hold this frame until every earlier word has come out
        drain_next   = 1'b1;
        drain_placed = 1'b1;
      end
      put_random_frame();
    end
    put_stream_end();
  endfunction

  function automatic int sender_idle_pct();
    if (bytes_sent < PHASE_A_END) return 26;
    if (bytes_sent < PHASE_B_END) return 81;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (bytes_sent < PHASE_A_END) return 81;
    if (bytes_sent < PHASE_B_END) return 26;
    return 0;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_stream_byte(in_stream_byte);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (stream_q.size() != 0 &&
            !(stream_q[0].drain_first && expected_words.size() != 0) &&
            $urandom_range(0, 99) >= sender_idle_pct()) begin
          next_word = stream_q.pop_front();
          in_valid       <= 1'b1;
          in_stream_byte <= next_word.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and checker
  always @(posedge clk) begin
    deframed_word_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none actual kind %0d byte %0h op %0h",
                   $time, out_kind, out_payload_byte, out_frame_opcode);
          mismatches++;
        end else begin
          w = expected_words.pop_front();
          compare_field("kind", 8'(w.kind), 8'(out_kind));
          compare_field("payload_byte", w.data, out_payload_byte);
          compare_field("frame_opcode", 8'(w.op), 8'(out_frame_opcode));
          compare_field("fin_bit", 8'(w.fin), 8'(out_fin_bit));
          compare_field("frame_last", 8'(w.frame_last), 8'(out_frame_last));
          compare_field("message_last", 8'(w.msg_last), 8'(out_message_last));
        end
      end
      // hold off once for a long stretch so the input backs up
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!stall_done && bytes_sent >= HOLD_AT) begin
        stall_done = 1'b1;
        stall_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    build_stream();
    stream_len = stream_q.size();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (bytes_sent < stream_len) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/wsfd_pkg.sv
rtl/websocket_frame_deframer_core.sv
rtl/wsfd_checker.sv
dv/tb_top.sv
